// ===== hw/rtl/char_lcd_refresh_encoder_macros.svh =====
// Assertion macros used by the controller of the character display refresh encoder.
`ifndef CHAR_LCD_REFRESH_ENCODER_MACROS_SVH
`define CHAR_LCD_REFRESH_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/clre_pkg.sv =====
// Constants, codes, types and tables of the character display refresh encoder.
package clre_pkg;

  localparam int unsigned MAX_COLUMNS = 40;
  localparam int unsigned MAX_ROWS    = 4;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_ON        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_ORDER_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_ORDER        = 3'd4;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Expander bit assignments and display constants
  localparam logic [7:0] SIG_BL    = 8'h08;
  localparam logic [7:0] SIG_EN    = 8'h04;
  localparam logic [7:0] SIG_RS    = 8'h01;
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] NIB_HI    = 8'hf0;
  localparam logic [7:0] SPACE     = 8'h20;

  localparam logic [15:0] ORDER_TWO_ROWS  = 16'h7710;
  localparam logic [15:0] ORDER_FOUR_ROWS = 16'h2103;

  // Clamp limits for the column and row counts
  localparam logic [6:0] COLS_MIN = 7'd16;
  localparam logic [6:0] COLS_MAX = 7'(MAX_COLUMNS);
  localparam logic [2:0] ROWS_MIN = 3'd2;
  localparam logic [2:0] ROWS_MAX = 3'(MAX_ROWS);

  // Six expander bytes per slot
  localparam int unsigned  BYTE_IDX_W = 3;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 3'd5;
  localparam logic [BYTE_IDX_W-1:0] HI_EN_BYTE = 3'd1;
  localparam logic [BYTE_IDX_W-1:0] LO_FIRST_BYTE = 3'd3;
  localparam logic [BYTE_IDX_W-1:0] LO_EN_BYTE = 3'd4;

  typedef struct packed {
    logic                  wr;
    logic                  clr;
    logic                  step;
    logic                  load;
    logic [BYTE_IDX_W-1:0] byte_idx;
  } clre_cmd_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      2'd3:    off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

endpackage

// ===== hw/rtl/clre_ifs.sv =====
// Valid/ready channel interfaces for request items and expander bytes.
interface clre_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] text_row;
  logic [5:0] text_col;
  logic [7:0] char_code;

  modport source(output valid, req_type, text_row, text_col, char_code, input ready);
  modport sink(input valid, req_type, text_row, text_col, char_code, output ready);
endinterface

interface clre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic       last;
  logic       row_end;
  logic [7:0] frame_count;

  modport source(output valid, expander_byte, last, row_end, frame_count, input ready);
  modport sink(input valid, expander_byte, last, row_end, frame_count, output ready);
endinterface

// ===== hw/rtl/clre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module clre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/clre_dp.sv =====
// Datapath: configuration, text store, refresh counters and byte formatting.
module clre_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [clre_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clre_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  clre_pkg::clre_cmd_t                  cmd,
  input  logic [1:0]                           text_row,
  input  logic [5:0]                           text_col,
  input  logic [7:0]                           char_code,
  output logic [7:0]                           expander_byte,
  output logic                                 last,
  output logic                                 row_end,
  output logic [7:0]                           frame_count
);

  localparam int unsigned AW = clre_pkg::ADDR_W;

  // Configuration registers
  logic [5:0]  column_count_r;
  logic [2:0]  row_count_r;
  logic        backlight_r;
  logic        order_en_r;
  logic [15:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= 6'd16;
      row_count_r    <= 3'd2;
      backlight_r    <= 1'b1;
      order_en_r     <= 1'b0;
      order_r        <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_index)
        clre_pkg::CFG_COLUMN_COUNT:        column_count_r <= cfg_data[5:0];
        clre_pkg::CFG_ROW_COUNT:           row_count_r    <= cfg_data[2:0];
        clre_pkg::CFG_BACKLIGHT_ON:        backlight_r    <= cfg_data[0];
        clre_pkg::CFG_CUSTOM_ORDER_ENABLE: order_en_r     <= cfg_data[0];
        clre_pkg::CFG_CUSTOM_ORDER:        order_r        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clamped counts
  logic [6:0] cols;
  logic [2:0] rows;

  always_comb begin
    if ({1'b0, column_count_r} < clre_pkg::COLS_MIN) begin
      cols = clre_pkg::COLS_MIN;
    end else if ({1'b0, column_count_r} > clre_pkg::COLS_MAX) begin
      cols = clre_pkg::COLS_MAX;
    end else begin
      cols = {1'b0, column_count_r};
    end
    if (row_count_r < clre_pkg::ROWS_MIN) begin
      rows = clre_pkg::ROWS_MIN;
    end else if (row_count_r > clre_pkg::ROWS_MAX) begin
      rows = clre_pkg::ROWS_MAX;
    end else begin
      rows = row_count_r;
    end
  end

  // Text store: RAM plus one valid bit per entry; an invalid entry reads as a space
  logic [clre_pkg::STORE_DEPTH-1:0] valid_r;
  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_q;

  assign wr_ok   = cmd.wr && (32'(text_row) < clre_pkg::MAX_ROWS) && ({1'b0, text_col} < cols);
  assign wr_addr = AW'(text_row) * AW'(clre_pkg::MAX_COLUMNS) + AW'(text_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Refresh counters
  logic [2:0] row_r,    row_nxt;
  logic [5:0] slot_r,   slot_nxt;
  logic [7:0] frames_r, frames_nxt;

  logic        slot_zero;
  logic        wrap;
  logic [2:0]  cmd_row;
  logic [15:0] order;
  logic [15:0] order_sh;
  logic [2:0]  trow;
  logic [5:0]  col;
  logic        use_ram;
  logic        step_row_end;

  always_comb begin
    slot_zero = (slot_r == 6'd0);
    wrap      = (row_r >= rows);
    cmd_row   = wrap ? 3'd0 : row_r;
    if (order_en_r) begin
      order = order_r;
    end else if (rows == clre_pkg::ROWS_MIN) begin
      order = clre_pkg::ORDER_TWO_ROWS;
    end else begin
      order = clre_pkg::ORDER_FOUR_ROWS;
    end
    order_sh     = order >> {row_r[1:0], 2'b00};
    trow         = order_sh[2:0];
    col          = slot_r - 6'd1;
    use_ram      = backlight_r && (32'(trow) < clre_pkg::MAX_ROWS) &&
                   (32'(col) < clre_pkg::MAX_COLUMNS);
    rd_addr      = AW'(trow) * AW'(clre_pkg::MAX_COLUMNS) + AW'(col);
    step_row_end = !slot_zero && ({1'b0, slot_r} >= cols);

    row_nxt    = row_r;
    slot_nxt   = slot_r;
    frames_nxt = frames_r;
    if (slot_zero) begin
      if (wrap) begin
        row_nxt    = 3'd0;
        frames_nxt = frames_r + 8'd1;
      end
      slot_nxt = 6'd1;
    end else if (step_row_end) begin
      slot_nxt = 6'd0;
      row_nxt  = row_r + 3'd1;
    end else begin
      slot_nxt = slot_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= 3'd0;
      slot_r   <= 6'd0;
      frames_r <= 8'd0;
    end else if (cmd.step) begin
      row_r    <= row_nxt;
      slot_r   <= slot_nxt;
      frames_r <= frames_nxt;
    end
  end

  clre_ram #(
    .WIDTH (8),
    .DEPTH (clre_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (char_code),
    .re    (cmd.step),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Slot payload, captured at the step and resolved after the store read
  logic       is_cmd_r;
  logic [7:0] cmd_val_r;
  logic       take_ram_r;
  logic [7:0] sig_r;
  logic       row_end_r;
  logic [7:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      is_cmd_r   <= slot_zero;
      cmd_val_r  <= clre_pkg::CMD_DDRAM | clre_pkg::row_offset(cmd_row[1:0]);
      take_ram_r <= use_ram && valid_r[rd_addr];
      sig_r      <= (slot_zero ? 8'h00 : clre_pkg::SIG_RS) |
                    (backlight_r ? clre_pkg::SIG_BL : 8'h00);
      row_end_r  <= step_row_end;
    end
    if (cmd.load) begin
      if (is_cmd_r) begin
        val_r <= cmd_val_r;
      end else if (take_ram_r) begin
        val_r <= ram_q;
      end else begin
        val_r <= clre_pkg::SPACE;
      end
    end
  end

  // Byte formatting: high nibble on bytes 0..2, low nibble on 3..5, EN on the middle byte of each
  logic [7:0] nib;
  logic       en_byte;

  always_comb begin
    nib     = (cmd.byte_idx < clre_pkg::LO_FIRST_BYTE) ? (val_r & clre_pkg::NIB_HI)
                                                        : {val_r[3:0], 4'h0};
    en_byte = (cmd.byte_idx == clre_pkg::HI_EN_BYTE) || (cmd.byte_idx == clre_pkg::LO_EN_BYTE);
    expander_byte = nib | sig_r | (en_byte ? clre_pkg::SIG_EN : 8'h00);
    last          = (cmd.byte_idx == clre_pkg::LAST_BYTE);
  end

  assign row_end     = row_end_r;
  assign frame_count = frames_r;

endmodule

// ===== hw/rtl/clre_ctrl.sv =====
// Controller: request acceptance, store read wait and six-byte output sequencing.
`include "char_lcd_refresh_encoder_macros.svh"

module clre_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_req_type,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output clre_pkg::clre_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [clre_pkg::BYTE_IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic                            acc;
  logic                            out_xfer;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign acc       = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  always_comb begin
    cmd.wr       = acc && (in_req_type == clre_pkg::REQ_WRITE);
    cmd.clr      = acc && (in_req_type == clre_pkg::REQ_CLEAR);
    cmd.step     = acc && (in_req_type == clre_pkg::REQ_STEP);
    cmd.load     = (state_r == ST_LOAD);
    cmd.byte_idx = byte_idx_r;
  end

  always_comb begin
    state_nxt    = state_r;
    byte_idx_nxt = byte_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.step) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt    = ST_EMIT;
        byte_idx_nxt = '0;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (byte_idx_r == clre_pkg::LAST_BYTE) begin
            state_nxt = ST_IDLE;
          end else begin
            byte_idx_nxt = byte_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  `CLRE_ASSERT_NEXT(a_step_loads, cmd.step, state_r == ST_LOAD, "step did not start a store read")
  `CLRE_ASSERT_NEXT(a_load_emits, state_r == ST_LOAD, out_valid && byte_idx_r == '0, "slot did not start at byte 0")
  `CLRE_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(byte_idx_r), "byte index moved during stall")
  `CLRE_ASSERT_NEXT(a_last_frees, out_xfer && byte_idx_r == clre_pkg::LAST_BYTE, in_ready, "input not freed after last byte")

endmodule

// ===== hw/rtl/char_lcd_refresh_encoder.sv =====
// Top level of the character display refresh encoder.
// Character display refresh encoder for a 4-bit display behind an I2C port
// expander. A request on in_ch is one of: write character (stored at
// text_row/text_col, dropped when the column is at or past the clamped
// column count), clear (whole text store back to spaces, done at once
// through per-entry valid bits, so there is no clearing pass after reset),
// or step, which emits the next refresh slot as six expander bytes on
// out_ch: high nibble then low nibble, each as plain / with EN / plain.
// Slot 0 of a physical row is the DDRAM address command; the remaining
// slots are characters with RS set, taken from the text row chosen by the
// row order map. Write, clear and unknown requests complete at acceptance.
// A step is accepted, waits in the load state for the registered text
// store read, then makes six output transfers, with in_ch ready again in
// the cycle after the sixth byte transfers; in_ch is not ready while a
// step is in progress. frame_count carries the number of completed frames,
// updated at the step that wraps the row counter. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module char_lcd_refresh_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clre_pkg::CFG_DATA_W-1:0] cfg_data,
  clre_in_if.sink                         in_ch,
  clre_out_if.source                      out_ch
);

  clre_pkg::clre_cmd_t cmd;

  // Sequence accepts, the store read wait and the six byte transfers
  clre_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd)
  );

  // Hold configuration, text store and counters; format each byte
  clre_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .text_row      (in_ch.text_row),
    .text_col      (in_ch.text_col),
    .char_code     (in_ch.char_code),
    .expander_byte (out_ch.expander_byte),
    .last          (out_ch.last),
    .row_end       (out_ch.row_end),
    .frame_count   (out_ch.frame_count)
  );

endmodule

// ===== tb/sv/char_lcd_refresh_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the character display refresh encoder with directed and random requests.
module char_lcd_refresh_encoder_tb;

  localparam int unsigned HOLD_LONG  = 150;  // receiver hold-off for the backpressure test
  localparam int unsigned WDOG_LIMIT = 1000; // cycles without any transfer before giving up
  localparam int unsigned SETTLE_CYC = 4;    // settle time after draining, with margin for a last write or clear
  localparam logic [1:0]  REQ_UNUSED = 2'd3; // request code the block must ignore

  // One expected transfer on the expander byte channel
  typedef struct packed {
    logic [7:0] xbyte;
    logic       last;
    logic       row_end;
    logic [7:0] frames;
  } lcd_byte_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [clre_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [clre_pkg::CFG_DATA_W-1:0] cfg_data;

  clre_in_if  in_ch ();
  clre_out_if out_ch ();

  char_lcd_refresh_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow of the display state: text store, refresh position and frame count
  logic [7:0] shadow_text [clre_pkg::MAX_ROWS][clre_pkg::MAX_COLUMNS];
  logic [2:0] shadow_row;
  logic [5:0] shadow_slot;
  logic [7:0] shadow_frames;

  // Shadow of the configuration registers, raw as written
  logic [5:0]  reg_cols;
  logic [2:0]  reg_rows;
  logic        reg_backlight;
  logic        reg_custom_en;
  logic [15:0] reg_order;

  // Expander bytes predicted but not yet seen on out_ch, oldest first
  lcd_byte_t pending_bytes [$];

  int unsigned error_count = 0;
  bit          idle_en     = 1'b1; // both sides insert random gaps while set
  bit          hold_req    = 1'b0; // ask the receiver for one long hold-off

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  function automatic void blank_text();
    foreach (shadow_text[r, c]) shadow_text[r][c] = clre_pkg::SPACE;
  endfunction

  // Column count as the block uses it: held to 16..MAX_COLUMNS
  function automatic int unsigned eff_cols();
    if (reg_cols < clre_pkg::COLS_MIN) return clre_pkg::COLS_MIN;
    if (reg_cols > clre_pkg::COLS_MAX) return clre_pkg::COLS_MAX;
    return reg_cols;
  endfunction

  // Apply one accepted request to the shadow state and queue the bytes it causes
  function automatic void encode_request(input logic [1:0] req, input logic [1:0] row,
                                         input logic [5:0] col, input logic [7:0] ch);
    int unsigned cols;
    int unsigned rows;
    logic [15:0] order;
    logic [2:0]  trow;
    logic [5:0]  tcol;
    logic [7:0]  val;
    logic [7:0]  sig;
    logic [7:0]  nib [2];
    logic        rend;
    lcd_byte_t   item;
    cols = eff_cols();
    rows = (reg_rows < clre_pkg::ROWS_MIN) ? clre_pkg::ROWS_MIN :
           (reg_rows > clre_pkg::ROWS_MAX) ? clre_pkg::ROWS_MAX : reg_rows;
    rend = 1'b0;
    if (req == clre_pkg::REQ_WRITE) begin
      // Drop writes at or past the column count
      if (col < cols) shadow_text[row][col] = ch;
    end else if (req == clre_pkg::REQ_CLEAR) begin
      blank_text();
    end else if (req == clre_pkg::REQ_STEP) begin
      if (shadow_slot == 0) begin
        // Row start: wrap the frame here, then send the DDRAM address command
        if (shadow_row >= rows) begin
          shadow_row    = 3'd0;
          shadow_frames = shadow_frames + 8'd1;
        end
        case (shadow_row[1:0])
          2'd0:    val = 8'h00;
          2'd1:    val = 8'h40;
          2'd2:    val = 8'h14;
          default: val = 8'h54;
        endcase
        val         = clre_pkg::CMD_DDRAM | val;
        sig         = 8'h00;
        shadow_slot = 6'd1;
      end else begin
        // Character slot: the order map picks the text row, 4..7 means blank
        if (reg_custom_en)
          order = reg_order;
        else
          order = (rows == 2) ? clre_pkg::ORDER_TWO_ROWS : clre_pkg::ORDER_FOUR_ROWS;
        trow  = 3'(order >> (shadow_row[1:0] * 4));
        tcol  = shadow_slot - 6'd1;
        if (reg_backlight && trow < clre_pkg::MAX_ROWS && tcol < clre_pkg::MAX_COLUMNS)
          val = shadow_text[trow[1:0]][tcol];
        else
          val = clre_pkg::SPACE;
        sig = clre_pkg::SIG_RS;
        // A shrunk column count ends the row at the next character slot
        if (shadow_slot >= cols) begin
          rend        = 1'b1;
          shadow_slot = 6'd0;
          shadow_row  = shadow_row + 3'd1;
        end else begin
          shadow_slot = shadow_slot + 6'd1;
        end
      end
      if (reg_backlight) sig = sig | clre_pkg::SIG_BL;
      nib[0] = (val & clre_pkg::NIB_HI) | sig;
      nib[1] = ((val << 4) & clre_pkg::NIB_HI) | sig;
      // Each nibble goes out plain, with EN, plain again
      for (int k = 0; k < 6; k++) begin
        item.xbyte   = (k % 3 == 1) ? (nib[k / 3] | clre_pkg::SIG_EN) : nib[k / 3];
        item.last    = (k == 5);
        item.row_end = rend;
        item.frames  = shadow_frames;
        pending_bytes.push_back(item);
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  task automatic put_reg(input logic [clre_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all five registers on consecutive edges; call only while the block is idle
  task automatic set_config(input logic [5:0] cols, input logic [2:0] rows, input logic bl,
                            input logic order_en, input logic [15:0] order);
    cfg_we <= 1'b1;
    put_reg(clre_pkg::CFG_COLUMN_COUNT, 16'(cols));
    put_reg(clre_pkg::CFG_ROW_COUNT, 16'(rows));
    put_reg(clre_pkg::CFG_BACKLIGHT_ON, 16'(bl));
    put_reg(clre_pkg::CFG_CUSTOM_ORDER_ENABLE, 16'(order_en));
    put_reg(clre_pkg::CFG_CUSTOM_ORDER, order);
    cfg_we        <= 1'b0;
    reg_cols      = cols;
    reg_rows      = rows;
    reg_backlight = bl;
    reg_custom_en = order_en;
    reg_order     = order;
  endtask

  // Offer one request, hold it until the block takes it, then predict
  task automatic send_item(input logic [1:0] req, input logic [1:0] row,
                           input logic [5:0] col, input logic [7:0] ch);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.text_row  <= row;
    in_ch.text_col  <= col;
    in_ch.char_code <= ch;
    do @(posedge clk); while (!in_ch.ready);
    encode_request(req, row, col, ch);
  endtask

  task automatic send_step();
    send_item(clre_pkg::REQ_STEP, 2'($urandom), 6'($urandom), 8'($urandom));
  endtask

  // Drop valid, wait out every predicted byte, then let the last request finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Mostly steps and in-range writes; a few clears, unknown codes and stray columns
  task automatic random_items(input int unsigned count, input int unsigned step_pct);
    int unsigned pick;
    logic [5:0]  col;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0)
        col = 6'($urandom_range(0, 63));
      else
        col = 6'($urandom_range(0, eff_cols() - 1));
      if (pick < step_pct)
        send_step();
      else if (pick < step_pct + 4)
        send_item(clre_pkg::REQ_CLEAR, 2'($urandom), 6'($urandom), 8'($urandom));
      else if (pick < step_pct + 7)
        send_item(REQ_UNUSED, 2'($urandom), 6'($urandom), 8'($urandom));
      else
        send_item(clre_pkg::REQ_WRITE, 2'($urandom), col, 8'($urandom));
    end
    drain();
  endtask

  // ------------------------------------------------------------------
  // Result checking: one process takes every byte transfer
  // ------------------------------------------------------------------

  initial begin : byte_sink
    int unsigned gap;
    lcd_byte_t   want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      // One long hold-off on request, else a random gap per byte
      if (hold_req) begin
        gap      = HOLD_LONG;
        hold_req = 1'b0;
      end else begin
        gap = idle_en ? $urandom_range(0, 14) : 0;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_bytes.size() == 0) begin
        $error("expander_byte: unexpected transfer, actual %h", out_ch.expander_byte);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.expander_byte !== want.xbyte) begin
          $error("expander_byte: expected %h, actual %h", want.xbyte, out_ch.expander_byte);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_ch.last);
          error_count++;
        end
        if (out_ch.row_end !== want.row_end) begin
          $error("row_end: expected %b, actual %b", want.row_end, out_ch.row_end);
          error_count++;
        end
        if (out_ch.frame_count !== want.frames) begin
          $error("frame_count: expected %0d, actual %0d", want.frames, out_ch.frame_count);
          error_count++;
        end
      end
    end
  end

  // End the run when neither channel has moved for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("char_lcd_refresh_encoder_tb NOT OK");
    $finish;
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Column and row extremes under the reset config (16 columns), stores past
  // the column count, and an unknown request code that must change nothing
  task automatic test_store_writes();
    send_item(clre_pkg::REQ_WRITE, 2'd0, 6'd0, 8'h00);
    send_item(clre_pkg::REQ_WRITE, 2'd0, 6'd1, 8'hff);
    send_item(clre_pkg::REQ_WRITE, 2'd0, 6'd15, 8'ha5);
    send_item(clre_pkg::REQ_WRITE, 2'd1, 6'd0, 8'h5a);
    send_item(clre_pkg::REQ_WRITE, 2'd3, 6'd15, 8'h7e);
    send_item(clre_pkg::REQ_WRITE, 2'd1, 6'd16, 8'h41);
    send_item(clre_pkg::REQ_WRITE, 2'd2, 6'd39, 8'h42);
    send_item(clre_pkg::REQ_WRITE, 2'd3, 6'd63, 8'h43);
    send_item(REQ_UNUSED, 2'd0, 6'd2, 8'h99);
    drain();
  endtask

  // Address command plus the first characters of row 0, then clear and show spaces
  task automatic test_refresh_and_clear();
    repeat (4) send_step();
    send_item(clre_pkg::REQ_CLEAR, 2'd3, 6'd63, 8'hff);
    repeat (2) send_step();
    drain();
  endtask

  // Hold the receiver off while the sender keeps offering steps back to back,
  // so the block fills and stalls its input
  task automatic test_output_backpressure();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    repeat (10) send_step();
    drain();
    idle_en = 1'b1;
  endtask

  // Advance mid-row at 40 columns, then shrink to the minimum: the next
  // character slot must end the row
  task automatic test_column_shrink();
    idle_en = 1'b0;
    set_config(6'd40, reg_rows, 1'b1, 1'b0, reg_order);
    while (shadow_slot < 6'd24) send_step();
    drain();
    set_config(6'd0, reg_rows, 1'b1, 1'b0, reg_order);
    repeat (3) send_step();
    drain();
    idle_en = 1'b1;
  endtask

  // Reset-value config with random gaps on both sides
  task automatic test_default_traffic();
    set_config(6'd16, 3'd2, 1'b1, 1'b0, 16'h0000);
    random_items(15, 70);
  endtask

  // Row count above the limit (four rows, default four-row map), column count
  // below the limit; no idling on either side
  task automatic test_four_rows();
    idle_en = 1'b0;
    set_config(6'd0, 3'd7, 1'b1, 1'b0, 16'h0000);
    random_items(15, 80);
    idle_en = 1'b1;
  endtask

  // Backlight off: BL clear and every character sent as a space
  task automatic test_backlight_off();
    set_config(6'd63, 3'd3, 1'b0, 1'b0, 16'hffff);
    random_items(14, 75);
  endtask

  // Custom map with high nibble bits set over two rows: text row 3 and a blank row
  task automatic test_custom_order();
    set_config(6'd40, 3'd1, 1'b1, 1'b1, 16'hc9fb);
    random_items(15, 70);
  endtask

  // Random custom map over four rows
  task automatic test_random_order();
    set_config(6'd16, 3'd4, 1'b1, 1'b1, 16'($urandom));
    random_items(14, 70);
  endtask

  initial begin : run
    // Drive every input to a known value before the first edge
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= clre_pkg::CFG_COLUMN_COUNT;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= clre_pkg::REQ_WRITE;
    in_ch.text_row  <= '0;
    in_ch.text_col  <= '0;
    in_ch.char_code <= '0;

    blank_text();
    shadow_row    = 3'd0;
    shadow_slot   = 6'd0;
    shadow_frames = 8'd0;
    reg_cols      = 6'd16;
    reg_rows      = 3'd2;
    reg_backlight = 1'b1;
    reg_custom_en = 1'b0;
    reg_order     = 16'h0000;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_store_writes();
    test_refresh_and_clear();
    test_output_backpressure();
    test_column_shrink();
    test_default_traffic();
    test_four_rows();
    test_backlight_off();
    test_custom_order();
    test_random_order();

    // Everything has drained; wait on so that any stray bytes would show
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("char_lcd_refresh_encoder_tb OK");
    else
      $display("char_lcd_refresh_encoder_tb NOT OK");
    $finish;
  end

endmodule
